/* rtl/small_matrix_arithmetic_unit_assert.svh */
// Assertion macros shared by the small matrix arithmetic unit RTL.
`ifndef SMALL_MATRIX_ARITHMETIC_UNIT_ASSERT_SVH
`define SMALL_MATRIX_ARITHMETIC_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define SMAU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("small matrix unit: same-cycle check failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define SMAU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("small matrix unit: next-cycle check failed");

`endif

/* rtl/smau_pkg.sv */
// Shared constants, codes and controller/datapath interface types.
package smau_pkg;

    // Default largest matrix dimension
    localparam int MAX_DIM_DEF = 4;

    // Fixed field widths
    localparam int ELEM_W    = 16;
    localparam int RES_W     = 35;
    localparam int PROD_W    = 32;
    localparam int REQ_W     = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_LOAD_A = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_B = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RUN    = 2'd2;

    // Operation modes
    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_MUL   = 2'd1;
    localparam logic [1:0] MODE_SCALE = 2'd2;
    localparam logic [1:0] MODE_TRANS = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_A = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_B = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 3'd5;

    // Configuration reset values
    localparam logic [1:0]                MODE_RST  = MODE_ADD;
    localparam logic [2:0]                DIM_RST   = 3'd2;
    localparam logic signed [ELEM_W-1:0]  SCALE_RST = 16'sd1;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_a;
        logic load_b;
        logic run_start;
        logic read;
        logic mul;
        logic acc;
        logic step_z;
        logic step_out;
        logic out_data;
        logic out_err;
    } smau_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic err;
        logic z_last;
        logic ent_last;
        logic out_free;
    } smau_stat_t;

endpackage

/* rtl/small_matrix_arithmetic_unit.sv */
// Top level of the small matrix arithmetic unit (add, multiply, scale, transpose).
//
// Input channel (s_valid/s_ready): one beat carries s_req_type and s_element.
// Load A and load B beats store the next element of A or B in row-major order
// and give no result; loads past rows*cols are dropped. A run beat walks the
// result matrix in row-major order, one result beat per entry on the m_ channel,
// m_last set on the final one; unsuitable sizes give a single beat with
// m_status set. A run clears both load counters.
// A run begins with a size check; if the sizes suit, each entry then takes K
// terms, where K is cols_a in multiply mode and 1 otherwise (one read, one
// multiply, one accumulate per term through the single multiplier).
// s_ready is low from a run beat until its last result is in the output register.
// A stalled receiver holds the output register; the walk then waits before
// pushing the next entry, and the input stays closed until the final entry
// has moved into the output register.
// Config (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready and must
// be written only while the block is idle.
// Reset (aresetn low, synchronous) restores register defaults, marks both
// stores empty so they read as zero, and clears the counters at once.
`include "small_matrix_arithmetic_unit_assert.svh"

module small_matrix_arithmetic_unit
    import smau_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [REQ_W-1:0]            s_req_type,
    input  logic signed [ELEM_W-1:0]    s_element,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [RES_W-1:0]     m_result_value,
    output logic [1:0]                  m_out_row,
    output logic [1:0]                  m_out_col,
    output logic                        m_status,
    output logic                        m_last,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DAT_W-1:0]        cfg_data
);

    smau_cmd_t  cmd;
    smau_stat_t stat;
    logic       err_beat_clean;

    assign cfg_ready = 1'b1;

    smau_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_req_type (s_req_type),
        .s_ready    (s_ready),
        .cmd        (cmd),
        .stat       (stat)
    );

    smau_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_element      (s_element),
        .cfg_valid      (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_result_value (m_result_value),
        .m_out_row      (m_out_row),
        .m_out_col      (m_out_col),
        .m_status       (m_status),
        .m_last         (m_last)
    );

    // An error beat is a lone, zeroed, final beat
    assign err_beat_clean = m_last && (m_result_value == '0) && (m_out_row == 2'd0) &&
                            (m_out_col == 2'd0);

    `SMAU_ASSERT_NOW(a_err_beat, m_valid && m_status, err_beat_clean)

    // A run beat closes the input until the walk is done
    `SMAU_ASSERT_NEXT(a_run_busy, s_valid && s_ready && (s_req_type == REQ_RUN), !s_ready)

    // Loads and unused requests keep the input open
    `SMAU_ASSERT_NEXT(a_load_open, s_valid && s_ready && (s_req_type != REQ_RUN), s_ready)

endmodule

/* rtl/smau_ctrl.sv */
// Sequencer for loads and run walks of the small matrix unit.
module smau_ctrl
    import smau_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic [REQ_W-1:0] s_req_type,
    output logic             s_ready,
    output smau_cmd_t        cmd,
    input  smau_stat_t       stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_MUL,
        S_ACC,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg;
    logic   accept;

    assign accept  = s_valid && s_ready_reg;
    assign s_ready = s_ready_reg;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (s_req_type)
                        REQ_LOAD_A: cmd.load_a = 1'b1;
                        REQ_LOAD_B: cmd.load_b = 1'b1;
                        REQ_RUN: begin
                            cmd.run_start = 1'b1;
                            state_next    = S_CHECK;
                        end
                        default: ;
                    endcase
                end
            end
            S_CHECK: begin
                if (stat.err) begin
                    if (stat.out_free) begin
                        cmd.out_err = 1'b1;
                        state_next  = S_IDLE;
                    end
                end else begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                cmd.read   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC: begin
                cmd.acc = 1'b1;
                if (stat.z_last) begin
                    state_next = S_OUT;
                end else begin
                    cmd.step_z = 1'b1;
                    state_next = S_READ;
                end
            end
            S_OUT: begin
                // wait for the output register to free up
                if (stat.out_free) begin
                    cmd.out_data = 1'b1;
                    cmd.step_out = 1'b1;
                    state_next   = stat.ent_last ? S_IDLE : S_READ;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State and registered ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= (state_next == S_IDLE);
        end
    end

endmodule

/* rtl/smau_dp.sv */
// Datapath: configuration, matrix stores, index counters, MAC and output register.
module smau_dp
    import smau_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  smau_cmd_t                   cmd,
    output smau_stat_t                  stat,
    input  logic signed [ELEM_W-1:0]    s_element,
    input  logic                        cfg_valid,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DAT_W-1:0]        cfg_data,
    input  logic                        m_ready,
    output logic                        m_valid,
    output logic signed [RES_W-1:0]     m_result_value,
    output logic [1:0]                  m_out_row,
    output logic [1:0]                  m_out_col,
    output logic                        m_status,
    output logic                        m_last
);

    localparam int CELLS = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(CELLS);
    localparam int IW    = $clog2(MAX_DIM);
    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int CW    = $clog2(CELLS + 1);

    // Clamp a size register to 1..MAX_DIM
    function automatic logic [DW-1:0] eff_dim(input logic [2:0] v);
        if (v == 3'd0) begin
            return DW'(1);
        end else if (int'(v) > MAX_DIM) begin
            return DW'(MAX_DIM);
        end else begin
            return DW'(v);
        end
    endfunction

    // Configuration registers
    logic [1:0]               mode_reg;
    logic [2:0]               rows_a_reg, cols_a_reg, rows_b_reg, cols_b_reg;
    logic signed [ELEM_W-1:0] scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_RST;
            rows_a_reg <= DIM_RST;
            cols_a_reg <= DIM_RST;
            rows_b_reg <= DIM_RST;
            cols_b_reg <= DIM_RST;
            scale_reg  <= SCALE_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MODE:   mode_reg   <= cfg_data[1:0];
                CFG_ROWS_A: rows_a_reg <= cfg_data[2:0];
                CFG_COLS_A: cols_a_reg <= cfg_data[2:0];
                CFG_ROWS_B: rows_b_reg <= cfg_data[2:0];
                CFG_COLS_B: cols_b_reg <= cfg_data[2:0];
                CFG_SCALE:  scale_reg  <= signed'(cfg_data);
                default: ;
            endcase
        end
    end

    // Effective sizes and result shape
    logic [DW-1:0] ra, ca, rb, cb;
    logic [DW-1:0] nr, nc, nz;
    logic [CW-1:0] size_a, size_b;
    logic          err;

    assign ra     = eff_dim(rows_a_reg);
    assign ca     = eff_dim(cols_a_reg);
    assign rb     = eff_dim(rows_b_reg);
    assign cb     = eff_dim(cols_b_reg);
    assign size_a = CW'(ra) * CW'(ca);
    assign size_b = CW'(rb) * CW'(cb);
    assign err    = ((mode_reg == MODE_ADD) && ((ra != rb) || (ca != cb))) ||
                    ((mode_reg == MODE_MUL) && (ca != rb));

    always_comb begin
        case (mode_reg)
            MODE_MUL: begin
                nr = ra;
                nc = cb;
                nz = ca;
            end
            MODE_TRANS: begin
                nr = ca;
                nc = ra;
                nz = DW'(1);
            end
            default: begin
                nr = ra;
                nc = ca;
                nz = DW'(1);
            end
        endcase
    end

    // Load counters and walk indexes
    logic [CW-1:0] cnt_a_reg, cnt_b_reg;
    logic [IW-1:0] i_reg, j_reg, z_reg;
    logic          load_ok_a, load_ok_b;
    logic          z_last, j_last, i_last;

    assign load_ok_a = cnt_a_reg < size_a;
    assign load_ok_b = cnt_b_reg < size_b;
    assign z_last    = (DW'(z_reg) + DW'(1)) == nz;
    assign j_last    = (DW'(j_reg) + DW'(1)) == nc;
    assign i_last    = (DW'(i_reg) + DW'(1)) == nr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            z_reg     <= '0;
        end else begin
            if (cmd.load_a && load_ok_a) begin
                cnt_a_reg <= cnt_a_reg + CW'(1);
            end
            if (cmd.load_b && load_ok_b) begin
                cnt_b_reg <= cnt_b_reg + CW'(1);
            end
            if (cmd.run_start) begin
                cnt_a_reg <= '0;
                cnt_b_reg <= '0;
                i_reg     <= '0;
                j_reg     <= '0;
                z_reg     <= '0;
            end
            if (cmd.step_z) begin
                z_reg <= z_reg + IW'(1);
            end
            // row-major step to the next result entry
            if (cmd.step_out) begin
                z_reg <= '0;
                if (j_last) begin
                    j_reg <= '0;
                    i_reg <= i_reg + IW'(1);
                end else begin
                    j_reg <= j_reg + IW'(1);
                end
            end
        end
    end

    // Store addresses for the current (i, j, z)
    logic [IW-1:0] ar, ac, br;
    logic [AW-1:0] addr_a, addr_b;

    always_comb begin
        case (mode_reg)
            MODE_MUL: begin
                ar = i_reg;
                ac = z_reg;
                br = z_reg;
            end
            MODE_TRANS: begin
                ar = j_reg;
                ac = i_reg;
                br = i_reg;
            end
            default: begin
                ar = i_reg;
                ac = j_reg;
                br = i_reg;
            end
        endcase
    end

    assign addr_a = AW'(ar) * AW'(ca) + AW'(ac);
    assign addr_b = AW'(br) * AW'(cb) + AW'(j_reg);

    // Matrix stores; valid bits make unwritten entries read as zero
    logic [ELEM_W-1:0] mem_a [CELLS];
    logic [ELEM_W-1:0] mem_b [CELLS];
    logic [CELLS-1:0]  vld_a_reg, vld_b_reg;
    logic [ELEM_W-1:0] rd_a_reg, rd_b_reg;
    logic              rd_va_reg, rd_vb_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_a && load_ok_a) begin
            mem_a[cnt_a_reg[AW-1:0]] <= s_element;
        end
        if (cmd.load_b && load_ok_b) begin
            mem_b[cnt_b_reg[AW-1:0]] <= s_element;
        end
        if (cmd.read) begin
            rd_a_reg <= mem_a[addr_a];
            rd_b_reg <= mem_b[addr_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_a_reg <= '0;
            vld_b_reg <= '0;
            rd_va_reg <= 1'b0;
            rd_vb_reg <= 1'b0;
        end else begin
            if (cmd.load_a && load_ok_a) begin
                vld_a_reg[cnt_a_reg[AW-1:0]] <= 1'b1;
            end
            if (cmd.load_b && load_ok_b) begin
                vld_b_reg[cnt_b_reg[AW-1:0]] <= 1'b1;
            end
            if (cmd.read) begin
                rd_va_reg <= vld_a_reg[addr_a];
                rd_vb_reg <= vld_b_reg[addr_b];
            end
        end
    end

    // Operand select and the shared multiplier
    logic signed [ELEM_W-1:0] a_val, b_val, op_b;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [RES_W-1:0]  acc_reg, acc_base;

    assign a_val = rd_va_reg ? signed'(rd_a_reg) : '0;
    assign b_val = rd_vb_reg ? signed'(rd_b_reg) : '0;
    assign op_b  = (mode_reg == MODE_SCALE) ? scale_reg : b_val;

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            case (mode_reg)
                MODE_ADD:   prod_reg <= PROD_W'(a_val) + PROD_W'(b_val);
                MODE_TRANS: prod_reg <= PROD_W'(a_val);
                default:    prod_reg <= PROD_W'(a_val) * PROD_W'(op_b);
            endcase
        end
    end

    // Accumulator restarts on the first term of each entry
    assign acc_base = (z_reg == '0) ? '0 : acc_reg;

    always_ff @(posedge aclk) begin
        if (cmd.acc) begin
            acc_reg <= acc_base + RES_W'(prod_reg);
        end
    end

    // Output register
    logic                    m_valid_reg;
    logic signed [RES_W-1:0] value_reg;
    logic [1:0]              row_reg, col_reg;
    logic                    status_reg, last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_data || cmd.out_err) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_err) begin
            value_reg  <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
            status_reg <= 1'b1;
            last_reg   <= 1'b1;
        end else if (cmd.out_data) begin
            value_reg  <= acc_reg;
            row_reg    <= 2'(i_reg);
            col_reg    <= 2'(j_reg);
            status_reg <= 1'b0;
            last_reg   <= i_last && j_last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = value_reg;
    assign m_out_row      = row_reg;
    assign m_out_col      = col_reg;
    assign m_status       = status_reg;
    assign m_last         = last_reg;

    // Status to the controller
    assign stat.err      = err;
    assign stat.z_last   = z_last;
    assign stat.ent_last = i_last && j_last;
    assign stat.out_free = !m_valid_reg || m_ready;

endmodule
